FILE: src/tsia_pkg.sv
package tsia_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int DIV_STEPS   = VALUE_WIDTH;

   localparam logic [3:0] CMD_ADD = 4'd0;
   localparam logic [3:0] CMD_SUB = 4'd1;
   localparam logic [3:0] CMD_MUL = 4'd2;
   localparam logic [3:0] CMD_DIV = 4'd3;
   localparam logic [3:0] CMD_MOD = 4'd4;
   localparam logic [3:0] CMD_NEG = 4'd5;
   localparam logic [3:0] CMD_EQ  = 4'd6;
   localparam logic [3:0] CMD_NE  = 4'd7;
   localparam logic [3:0] CMD_LT  = 4'd8;
   localparam logic [3:0] CMD_LE  = 4'd9;
   localparam logic [3:0] CMD_GT  = 4'd10;
   localparam logic [3:0] CMD_GE  = 4'd11;

   localparam logic [1:0] KIND_UNDEF = 2'd0;
   localparam logic [1:0] KIND_FIN   = 2'd1;
   localparam logic [1:0] KIND_PINF  = 2'd2;
   localparam logic [1:0] KIND_NINF  = 2'd3;

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [3:0]                    command;
      logic [1:0]                    a_kind;
      logic signed [VALUE_WIDTH-1:0] a_value;
      logic [1:0]                    b_kind;
      logic signed [VALUE_WIDTH-1:0] b_value;
   } req_type;

   typedef struct packed {
      logic [1:0]                    result_kind;
      logic signed [VALUE_WIDTH-1:0] result_value;
      logic                          compare_true;
   } rsp_type;

endpackage

FILE: src/tsia_req_if.sv
interface tsia_req_if import tsia_pkg::*;;
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/tsia_rsp_if.sv
interface tsia_rsp_if import tsia_pkg::*;;
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/tagged_saturating_integer_alu.sv
// Tagged saturating integer ALU.
// Requests arrive on req_bus (valid/ready); each carries a command and two
// tagged operands. Every request gives exactly one response on rsp_bus, in
// order. The block is a single pipeline: an input register, an arithmetic
// stage (add, subtract, compare and a 32 by 32 multiply), a resolve stage
// that settles all special cases, then a restoring divider of one quotient
// bit per stage, and an output register.
// Every command, from acceptance of a request to its response being offered,
// passes through every stage, the divider's bit-per-stage chain included.
// Throughput is one request per cycle while the receiver keeps ready high.
// When the receiver holds ready low with a response waiting, the whole
// pipeline freezes and req_bus.ready falls in the same cycle; nothing is
// dropped or repeated, and flow resumes as soon as the response is taken.
// Reset (synchronous, active high) clears every stage valid bit, so the
// pipeline is empty afterwards and requests are accepted at once.
module tagged_saturating_integer_alu
   import tsia_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   tsia_req_if.sink   req_bus,
   tsia_rsp_if.source rsp_bus
);

   localparam int W = VALUE_WIDTH;

   typedef struct packed {
      logic [3:0]       cmd;
      logic [1:0]       ak;
      logic [1:0]       bk;
      logic signed [W-1:0] a;
      logic signed [W-1:0] b;
      logic signed [W:0]   sum;
      logic signed [W:0]   dif;
      logic [2*W-1:0]      prod;
      logic [W-1:0]        ma;
      logic [W-1:0]        mb;
      logic                lt;
      logic                eq;
   } arith_type;

   typedef struct packed {
      logic [1:0]   kind;
      logic [W-1:0] val;
      logic         cmp;
      logic         need_div;
      logic         is_mod;
      logic         q_neg;
      logic         r_neg;
      logic [W:0]   rem;
      logic [W-1:0] quo;
      logic [W-1:0] dvs;
   } div_type;

   logic      adv;
   logic      s1_v_ff;
   req_type   s1_ff;
   logic      s2_v_ff;
   arith_type s2_ff;
   arith_type s2_in;
   div_type   s3_in;
   logic [DIV_STEPS:0] dv_v_ff;
   div_type   dv_ff [0:DIV_STEPS];
   logic      rsp_v_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;

   assign adv           = !rsp_v_ff || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign rsp_bus.valid = rsp_v_ff;
   assign rsp_bus.payload = rsp_ff;

   function automatic div_type div_step(input div_type d);
      div_type      r;
      logic [W:0]   sh;
      logic [W+1:0] df;
      r  = d;
      sh = {d.rem[W-1:0], d.quo[W-1]};
      df = {1'b0, sh} - {2'b00, d.dvs};
      if (!df[W+1]) begin
         r.rem = df[W:0];
         r.quo = {d.quo[W-2:0], 1'b1};
      end else begin
         r.rem = sh;
         r.quo = {d.quo[W-2:0], 1'b0};
      end
      return r;
   endfunction

   // Arithmetic stage.
   always_comb begin
      s2_in.cmd = s1_ff.command;
      s2_in.ak  = s1_ff.a_kind;
      s2_in.bk  = s1_ff.b_kind;
      s2_in.a   = s1_ff.a_value;
      s2_in.b   = s1_ff.b_value;
      s2_in.sum = {s1_ff.a_value[W-1], s1_ff.a_value} + {s1_ff.b_value[W-1], s1_ff.b_value};
      s2_in.dif = {s1_ff.a_value[W-1], s1_ff.a_value} - {s1_ff.b_value[W-1], s1_ff.b_value};
      s2_in.ma  = s1_ff.a_value[W-1] ? W'(-s1_ff.a_value) : s1_ff.a_value;
      s2_in.mb  = s1_ff.b_value[W-1] ? W'(-s1_ff.b_value) : s1_ff.b_value;
      s2_in.prod = {{W{1'b0}}, s2_in.ma} * {{W{1'b0}}, s2_in.mb};
      s2_in.lt  = s1_ff.a_value < s1_ff.b_value;
      s2_in.eq  = s1_ff.a_value == s1_ff.b_value;
   end

   // Resolve stage: every case except a real division is settled here.
   always_comb begin
      logic            both, a_inf, b_inf, a_zero, b_zero, f_neg, f_zero, p_neg;
      logic [1:0]      ik;
      logic [2*W-1:0]  limit;
      logic signed [W:0] smax, smin;
      both   = s2_ff.ak == KIND_FIN && s2_ff.bk == KIND_FIN;
      a_inf  = s2_ff.ak == KIND_PINF || s2_ff.ak == KIND_NINF;
      b_inf  = s2_ff.bk == KIND_PINF || s2_ff.bk == KIND_NINF;
      a_zero = s2_ff.ak == KIND_FIN && s2_ff.a == '0;
      b_zero = s2_ff.bk == KIND_FIN && s2_ff.b == '0;
      smax   = {1'b0, VALUE_MAX};
      smin   = {1'b1, VALUE_MIN};
      p_neg  = s2_ff.a[W-1] ^ s2_ff.b[W-1];
      limit  = p_neg ? (2*W)'({1'b0, VALUE_MIN}) : (2*W)'(VALUE_MAX);
      // For multiply by an infinity, f is the other operand.
      if (a_inf) begin
         ik     = s2_ff.ak;
         f_zero = b_zero;
         f_neg  = (s2_ff.bk == KIND_FIN && s2_ff.b[W-1]) || s2_ff.bk == KIND_NINF;
      end else begin
         ik     = s2_ff.bk;
         f_zero = a_zero;
         f_neg  = (s2_ff.ak == KIND_FIN && s2_ff.a[W-1]) || s2_ff.ak == KIND_NINF;
      end

      s3_in          = '0;
      s3_in.kind     = KIND_UNDEF;
      s3_in.is_mod   = s2_ff.cmd == CMD_MOD;
      s3_in.q_neg    = p_neg;
      s3_in.r_neg    = s2_ff.a[W-1];
      s3_in.quo      = s2_ff.ma;
      s3_in.dvs      = s2_ff.mb;
      case (s2_ff.cmd)
         CMD_ADD: begin
            if (s2_ff.ak == KIND_UNDEF || s2_ff.bk == KIND_UNDEF) begin
               s3_in.kind = KIND_UNDEF;
            end else if (a_inf && b_inf) begin
               s3_in.kind = (s2_ff.ak == s2_ff.bk) ? s2_ff.ak : KIND_UNDEF;
            end else if (a_inf) begin
               s3_in.kind = s2_ff.ak;
            end else if (b_inf) begin
               s3_in.kind = s2_ff.bk;
            end else if (s2_ff.sum > smax) begin
               s3_in.kind = KIND_PINF;
            end else if (s2_ff.sum < smin) begin
               s3_in.kind = KIND_NINF;
            end else begin
               s3_in.kind = KIND_FIN;
               s3_in.val  = s2_ff.sum[W-1:0];
            end
         end
         CMD_SUB: begin
            if (s2_ff.ak == KIND_UNDEF || s2_ff.bk == KIND_UNDEF) begin
               s3_in.kind = KIND_UNDEF;
            end else if (a_inf && b_inf) begin
               s3_in.kind = (s2_ff.ak != s2_ff.bk) ? s2_ff.ak : KIND_UNDEF;
            end else if (a_inf) begin
               s3_in.kind = s2_ff.ak;
            end else if (b_inf) begin
               s3_in.kind = (s2_ff.bk == KIND_PINF) ? KIND_NINF : KIND_PINF;
            end else if (s2_ff.dif > smax) begin
               s3_in.kind = KIND_PINF;
            end else if (s2_ff.dif < smin) begin
               s3_in.kind = KIND_NINF;
            end else begin
               s3_in.kind = KIND_FIN;
               s3_in.val  = s2_ff.dif[W-1:0];
            end
         end
         CMD_MUL: begin
            if (s2_ff.ak == KIND_UNDEF || s2_ff.bk == KIND_UNDEF) begin
               s3_in.kind = KIND_UNDEF;
            end else if (a_inf || b_inf) begin
               if (f_zero) begin
                  s3_in.kind = KIND_UNDEF;
               end else begin
                  s3_in.kind = ((ik == KIND_NINF) != f_neg) ? KIND_NINF : KIND_PINF;
               end
            end else if (s2_ff.prod == '0) begin
               s3_in.kind = KIND_FIN;
            end else if (s2_ff.prod > limit) begin
               s3_in.kind = p_neg ? KIND_NINF : KIND_PINF;
            end else begin
               s3_in.kind = KIND_FIN;
               s3_in.val  = p_neg ? W'(-s2_ff.prod[W-1:0]) : s2_ff.prod[W-1:0];
            end
         end
         CMD_DIV: begin
            if (b_zero || s2_ff.ak == KIND_UNDEF || s2_ff.bk == KIND_UNDEF) begin
               s3_in.kind = KIND_UNDEF;
            end else if (a_inf) begin
               if (b_inf) begin
                  s3_in.kind = KIND_UNDEF;
               end else begin
                  s3_in.kind = ((s2_ff.ak == KIND_NINF) != s2_ff.b[W-1]) ?
                               KIND_NINF : KIND_PINF;
               end
            end else if (a_zero || b_inf) begin
               s3_in.kind = KIND_FIN;
            end else if (s2_ff.a == VALUE_MIN && s2_ff.b == '1) begin
               s3_in.kind = KIND_PINF;
            end else begin
               s3_in.kind     = KIND_FIN;
               s3_in.need_div = 1'b1;
            end
         end
         CMD_MOD: begin
            if (b_zero || s2_ff.ak == KIND_UNDEF || s2_ff.bk == KIND_UNDEF) begin
               s3_in.kind = KIND_UNDEF;
            end else if (a_zero) begin
               s3_in.kind = KIND_FIN;
            end else if (!a_inf && b_inf) begin
               s3_in.kind = KIND_FIN;
               s3_in.val  = s2_ff.a;
            end else if (!b_inf && (s2_ff.b == W'(1) || s2_ff.b == '1)) begin
               s3_in.kind = KIND_FIN;
            end else if (a_inf) begin
               s3_in.kind = KIND_UNDEF;
            end else begin
               // Also covers a positive dividend over the minimum value.
               s3_in.kind     = KIND_FIN;
               s3_in.need_div = 1'b1;
            end
         end
         CMD_NEG: begin
            case (s2_ff.ak)
               KIND_FIN: begin
                  if (s2_ff.a == VALUE_MIN) begin
                     s3_in.kind = KIND_PINF;
                  end else begin
                     s3_in.kind = KIND_FIN;
                     s3_in.val  = W'(-s2_ff.a);
                  end
               end
               KIND_PINF: s3_in.kind = KIND_NINF;
               KIND_NINF: s3_in.kind = KIND_PINF;
               default:   s3_in.kind = KIND_UNDEF;
            endcase
         end
         CMD_EQ:  s3_in.cmp = both && s2_ff.eq;
         CMD_NE:  s3_in.cmp = both && !s2_ff.eq;
         CMD_LT:  s3_in.cmp = both && s2_ff.lt;
         CMD_LE:  s3_in.cmp = both && (s2_ff.lt || s2_ff.eq);
         CMD_GT:  s3_in.cmp = both && !(s2_ff.lt || s2_ff.eq);
         CMD_GE:  s3_in.cmp = both && !s2_ff.lt;
         default: s3_in.cmp = 1'b0;
      endcase
   end

   // Output stage: pick quotient or remainder and normalise the value.
   always_comb begin
      div_type      d;
      logic [W-1:0] v;
      d = dv_ff[DIV_STEPS];
      if (d.need_div) begin
         if (d.is_mod) begin
            v = d.r_neg ? W'(-d.rem[W-1:0]) : d.rem[W-1:0];
         end else begin
            v = d.q_neg ? W'(-d.quo) : d.quo;
         end
      end else begin
         v = d.val;
      end
      rsp_in.result_kind  = d.kind;
      rsp_in.compare_true = d.cmp;
      case (d.kind)
         KIND_FIN:  rsp_in.result_value = v;
         KIND_PINF: rsp_in.result_value = VALUE_MAX;
         KIND_NINF: rsp_in.result_value = VALUE_MIN;
         default:   rsp_in.result_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         dv_v_ff  <= '0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= req_bus.valid;
         s2_v_ff  <= s1_v_ff;
         dv_v_ff  <= {dv_v_ff[DIV_STEPS-1:0], s2_v_ff};
         rsp_v_ff <= dv_v_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff    <= req_bus.payload;
         s2_ff    <= s2_in;
         dv_ff[0] <= s3_in;
         for (int k = 0; k < DIV_STEPS; k++) begin
            dv_ff[k+1] <= div_step(dv_ff[k]);
         end
         rsp_ff   <= rsp_in;
      end
   end

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dv_v_ff) && $stable(s1_v_ff) && $stable(s2_v_ff))
      else $error("pipeline moved while the response was stalled");

   a_cmp_only: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.compare_true |->
         rsp_ff.result_kind == KIND_UNDEF && rsp_ff.result_value == '0)
      else $error("comparison response carries an arithmetic result");

   a_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.result_kind == KIND_PINF |-> rsp_ff.result_value == VALUE_MAX)
      else $error("plus infinity not normalised");

endmodule

FILE: tb/tb_channels.sv
`timescale 1ns / 1ps

// Testbench-side copies of the channels are not needed: the block's own
// interfaces (tsia_req_if, tsia_rsp_if) are used directly. This file holds a
// small package of shared stimulus helpers.
package tb_alu_pkg;
   import tsia_pkg::*;

   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return '0;
         3: return 1;
         4: return '1;
         5: return $signed($urandom_range(0, 20)) - 10;
         6: return $urandom_range(0, 65535);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return KIND_FIN;
      if (r < 80) return KIND_PINF;
      if (r < 90) return KIND_NINF;
      return KIND_UNDEF;
   endfunction
endpackage

FILE: tb/alu_checker.sv
`timescale 1ns / 1ps

module alu_checker
   import tsia_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  req_type req_payload,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  rsp_type rsp_payload,
   output int   failures,
   output int   pending,
   output int   responses_seen
);

   typedef struct {
      logic [1:0] kind;
      longint     v;
   } tagged_num;

   rsp_type expected_rsps[$];

   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;

   function automatic tagged_num tn(logic [1:0] k, longint v);
      tagged_num t;
      t.kind = k;
      t.v = v;
      return t;
   endfunction

   function automatic tagged_num inf_sign(bit negative);
      return negative ? tn(KIND_NINF, 0) : tn(KIND_PINF, 0);
   endfunction

   function automatic bit is_inf(tagged_num t);
      return t.kind == KIND_PINF || t.kind == KIND_NINF;
   endfunction

   function automatic bit is_zero(tagged_num t);
      return t.kind == KIND_FIN && t.v == 0;
   endfunction

   function automatic tagged_num do_add(tagged_num a, tagged_num b);
      longint s;
      if (a.kind == KIND_UNDEF || b.kind == KIND_UNDEF) return tn(KIND_UNDEF, 0);
      if (a.kind == KIND_PINF && b.kind == KIND_PINF) return tn(KIND_PINF, 0);
      if (a.kind == KIND_NINF && b.kind == KIND_NINF) return tn(KIND_NINF, 0);
      if (a.kind != KIND_FIN && b.kind != KIND_FIN) return tn(KIND_UNDEF, 0);
      if (a.kind != KIND_FIN) return a;
      if (b.kind != KIND_FIN) return b;
      s = a.v + b.v;
      if (s > VMAX) return tn(KIND_PINF, 0);
      if (s < VMIN) return tn(KIND_NINF, 0);
      return tn(KIND_FIN, s);
   endfunction

   function automatic tagged_num do_sub(tagged_num a, tagged_num b);
      longint s;
      if (a.kind == KIND_UNDEF || b.kind == KIND_UNDEF) return tn(KIND_UNDEF, 0);
      if (a.kind == KIND_PINF && b.kind == KIND_NINF) return tn(KIND_PINF, 0);
      if (a.kind == KIND_NINF && b.kind == KIND_PINF) return tn(KIND_NINF, 0);
      if (a.kind != KIND_FIN && b.kind != KIND_FIN) return tn(KIND_UNDEF, 0);
      if (a.kind != KIND_FIN) return a;
      if (b.kind != KIND_FIN) return inf_sign(b.kind == KIND_PINF);
      s = a.v - b.v;
      if (s > VMAX) return tn(KIND_PINF, 0);
      if (s < VMIN) return tn(KIND_NINF, 0);
      return tn(KIND_FIN, s);
   endfunction

   function automatic tagged_num do_mul(tagged_num a, tagged_num b);
      tagged_num f, i;
      longint p;
      if (a.kind == KIND_UNDEF || b.kind == KIND_UNDEF) return tn(KIND_UNDEF, 0);
      if (is_inf(a) || is_inf(b)) begin
         f = is_inf(a) ? b : a;
         i = is_inf(a) ? a : b;
         if (is_zero(f)) return tn(KIND_UNDEF, 0);
         return inf_sign((i.kind == KIND_NINF) !=
                         ((f.kind == KIND_FIN && f.v < 0) || f.kind == KIND_NINF));
      end
      // Both fit in 32 bits, so the 64-bit product is exact.
      p = a.v * b.v;
      if (p > VMAX) return tn(KIND_PINF, 0);
      if (p < VMIN) return tn(KIND_NINF, 0);
      return tn(KIND_FIN, p);
   endfunction

   function automatic tagged_num do_div(tagged_num a, tagged_num b);
      if (is_zero(b) || a.kind == KIND_UNDEF || b.kind == KIND_UNDEF)
         return tn(KIND_UNDEF, 0);
      if (is_inf(a)) begin
         if (is_inf(b)) return tn(KIND_UNDEF, 0);
         return inf_sign((a.kind == KIND_NINF) != (b.v < 0));
      end
      if (a.v == 0 || is_inf(b)) return tn(KIND_FIN, 0);
      if (a.v == VMIN && b.v == -1) return tn(KIND_PINF, 0);
      return tn(KIND_FIN, a.v / b.v);
   endfunction

   function automatic tagged_num do_mod(tagged_num a, tagged_num b);
      if (is_zero(b) || a.kind == KIND_UNDEF || b.kind == KIND_UNDEF)
         return tn(KIND_UNDEF, 0);
      if (is_zero(a)) return tn(KIND_FIN, 0);
      if (!is_inf(a) && is_inf(b)) return a;
      // Infinite divisors carry a value of zero, as in the finite check below.
      if (!is_inf(a) && a.v > 0 && b.v == VMIN) return a;
      if (!is_inf(b) && (b.v == 1 || b.v == -1)) return tn(KIND_FIN, 0);
      if (is_inf(a)) return tn(KIND_UNDEF, 0);
      return tn(KIND_FIN, a.v % b.v);
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      tagged_num a, b, res;
      bit both, holds;
      rsp_type o;
      a = tn(r.a_kind, r.a_kind == KIND_FIN ? longint'(r.a_value) : 0);
      b = tn(r.b_kind, r.b_kind == KIND_FIN ? longint'(r.b_value) : 0);
      res = tn(KIND_UNDEF, 0);
      both = a.kind == KIND_FIN && b.kind == KIND_FIN;
      holds = 0;
      case (r.command)
         CMD_ADD: res = do_add(a, b);
         CMD_SUB: res = do_sub(a, b);
         CMD_MUL: res = do_mul(a, b);
         CMD_DIV: res = do_div(a, b);
         CMD_MOD: res = do_mod(a, b);
         CMD_NEG: begin
            if (a.kind == KIND_FIN)
               res = a.v == VMIN ? tn(KIND_PINF, 0) : tn(KIND_FIN, -a.v);
            else if (a.kind == KIND_PINF) res = tn(KIND_NINF, 0);
            else if (a.kind == KIND_NINF) res = tn(KIND_PINF, 0);
         end
         CMD_EQ: holds = both && a.v == b.v;
         CMD_NE: holds = both && a.v != b.v;
         CMD_LT: holds = both && a.v < b.v;
         CMD_LE: holds = both && a.v <= b.v;
         CMD_GT: holds = both && a.v > b.v;
         CMD_GE: holds = both && a.v >= b.v;
         default: ;
      endcase
      o.result_kind = res.kind;
      case (res.kind)
         KIND_FIN:  o.result_value = res.v[VALUE_WIDTH-1:0];
         KIND_PINF: o.result_value = VALUE_MAX;
         KIND_NINF: o.result_value = VALUE_MIN;
         default:   o.result_value = '0;
      endcase
      o.compare_true = holds;
      return o;
   endfunction

   always_ff @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         failures <= 0;
         responses_seen <= 0;
         pending <= 0;
         expected_rsps.delete();
      end else begin
         if (req_valid && req_ready)
            expected_rsps.push_back(predict_rsp(req_payload));
         if (rsp_valid && rsp_ready) begin
            responses_seen <= responses_seen + 1;
            if (expected_rsps.size() == 0) begin
               $display("%0t: response with nothing expected: kind %0d value %0d cmp %0b",
                        $time, rsp_payload.result_kind, rsp_payload.result_value,
                        rsp_payload.compare_true);
               failures <= failures + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (want !== rsp_payload) begin
                  $display("%0t: mismatch: expected kind %0d value %0d cmp %0b,",
                           $time, want.result_kind, want.result_value,
                           want.compare_true);
                  $display("   actual kind %0d value %0d cmp %0b",
                           rsp_payload.result_kind, rsp_payload.result_value,
                           rsp_payload.compare_true);
                  failures <= failures + 1;
               end
            end
         end
         pending <= expected_rsps.size();
      end
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tsia_pkg::*;
   import tb_alu_pkg::*;

   logic clock;
   logic reset;
   int   failures, pending, responses_seen;
   int   sent;
   bit   calm_stretch;
   bit   hold_off;

   tsia_req_if req_bus ();
   tsia_rsp_if rsp_bus ();

   tagged_saturating_integer_alu uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   alu_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_payload    (req_bus.payload),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_payload    (rsp_bus.payload),
      .failures       (failures),
      .pending        (pending),
      .responses_seen (responses_seen)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic req_type make_req(logic [3:0] c, logic [1:0] ak, logic [31:0] av,
                                        logic [1:0] bk, logic [31:0] bv);
      req_type r;
      r.command = c;
      r.a_kind = ak;
      r.a_value = av;
      r.b_kind = bk;
      r.b_value = bv;
      return r;
   endfunction

   // Offers one request and holds it until it is taken.
   task automatic send_request(req_type r);
      while (!calm_stretch && $urandom_range(0, 99) < 6) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
   endtask

   task automatic run_directed();
      req_type d[$];
      d.push_back(make_req(CMD_ADD, KIND_FIN, VALUE_MAX, KIND_FIN, 1));
      d.push_back(make_req(CMD_ADD, KIND_FIN, VALUE_MIN, KIND_FIN, '1));
      d.push_back(make_req(CMD_ADD, KIND_PINF, 0, KIND_NINF, 0));
      d.push_back(make_req(CMD_SUB, KIND_FIN, VALUE_MIN, KIND_FIN, 1));
      d.push_back(make_req(CMD_SUB, KIND_FIN, 5, KIND_PINF, 0));
      d.push_back(make_req(CMD_SUB, KIND_NINF, 0, KIND_NINF, 0));
      d.push_back(make_req(CMD_MUL, KIND_PINF, 0, KIND_FIN, 0));
      d.push_back(make_req(CMD_MUL, KIND_FIN, 65536, KIND_FIN, -32768));
      d.push_back(make_req(CMD_MUL, KIND_FIN, VALUE_MAX, KIND_FIN, VALUE_MAX));
      d.push_back(make_req(CMD_MUL, KIND_NINF, 0, KIND_FIN, -3));
      d.push_back(make_req(CMD_DIV, KIND_FIN, VALUE_MIN, KIND_FIN, '1));
      d.push_back(make_req(CMD_DIV, KIND_FIN, 7, KIND_FIN, 0));
      d.push_back(make_req(CMD_DIV, KIND_FIN, -7, KIND_FIN, 2));
      d.push_back(make_req(CMD_DIV, KIND_PINF, 0, KIND_NINF, 0));
      d.push_back(make_req(CMD_DIV, KIND_FIN, 9, KIND_NINF, 0));
      d.push_back(make_req(CMD_MOD, KIND_FIN, -7, KIND_FIN, 2));
      d.push_back(make_req(CMD_MOD, KIND_FIN, 7, KIND_FIN, VALUE_MIN));
      d.push_back(make_req(CMD_MOD, KIND_PINF, 0, KIND_FIN, '1));
      d.push_back(make_req(CMD_MOD, KIND_NINF, 0, KIND_FIN, 3));
      d.push_back(make_req(CMD_MOD, KIND_FIN, 5, KIND_PINF, 0));
      d.push_back(make_req(CMD_NEG, KIND_FIN, VALUE_MIN, KIND_UNDEF, '1));
      d.push_back(make_req(CMD_NEG, KIND_PINF, 0, KIND_FIN, 0));
      d.push_back(make_req(CMD_LT, KIND_FIN, VALUE_MIN, KIND_FIN, VALUE_MAX));
      d.push_back(make_req(CMD_EQ, KIND_PINF, 0, KIND_PINF, 0));
      d.push_back(make_req(4'd15, KIND_FIN, '1, KIND_FIN, '1));
      foreach (d[i]) send_request(d[i]);
   endtask

   initial begin
      req_type r;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      sent = 0;
      calm_stretch = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int n = 0; n < 1450; n++) begin
         calm_stretch = n >= 400 && n < 600;
         r.command = $urandom_range(0, 99) < 3 ? 4'($urandom_range(12, 15))
                                               : 4'($urandom_range(0, 11));
         r.a_kind  = pick_kind();
         r.b_kind  = pick_kind();
         r.a_value = pick_value();
         r.b_value = pick_value();
         send_request(r);
      end
      req_bus.valid <= 1'b0;
      wait (pending == 0);
      repeat (50) @(posedge clock);
      $display("Sent %0d requests covering all commands, operand kinds and edge values;",
               sent);
      $display("%0d responses checked under random and long back-pressure.",
               responses_seen);
      if (failures == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off to fill the pipeline.
   initial begin
      rsp_bus.ready = 1'b0;
      hold_off = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (sent >= 800 && !hold_off) begin
            hold_off = 1;
            rsp_bus.ready <= 1'b0;
            repeat (120) @(posedge clock);
         end
         rsp_bus.ready <= calm_stretch || $urandom_range(0, 99) >= 6;
      end
   end

   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
src/tsia_pkg.sv
src/tsia_req_if.sv
src/tsia_rsp_if.sv
src/tagged_saturating_integer_alu.sv
tb/tb_channels.sv
tb/alu_checker.sv
tb/testbench.sv
